### hdl/sse_pkg.sv
// ----------------------------------------------------------------------------
// Summary statistics package
// Shared constants, job word and arithmetic unit request types.
// ----------------------------------------------------------------------------
package sse_pkg;

  localparam int MaxSamples = 4096;
  localparam int FracBits   = 16;
  localparam int AddrW      = $clog2(MaxSamples);
  localparam int CntW       = AddrW + 1;
  localparam int SumW       = 44;
  localparam int AluW       = 144;
  localparam int AluCntW    = 8;

  typedef enum logic [2:0] {
    OpMul  = 3'b001,
    OpDiv  = 3'b010,
    OpSqrt = 3'b100
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

  typedef struct packed {
    logic [CntW-1:0]        n;
    logic signed [SumW-1:0] sum;
    logic signed [31:0]     min;
    logic signed [31:0]     max;
    logic                   ovr;
  } job_t;

endpackage

### hdl/summary_statistics_engine.sv
// ----------------------------------------------------------------------------
// Summary statistics engine
// Loads signed Q16.16 samples into a store and reports count, sum, mean,
// variance, deviations, extremes and skewness for each data set.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake             Word
// samples   in         start, busy           sample_i, last_sample_i
// results   out        done_o (one cycle)    count_o .. overrun_o
//
// A sample takes one cycle when busy is low. After the last sample of a set,
// busy stays high while the sequencer divides for the mean and reads the store
// once, and longer when the sequencer is still on the previous set; the next
// set then loads while the arithmetic finishes. Sets of two or more samples
// go on to the variance and deviation steps on the serial divider, multiplier
// and root unit, and sets of three or more with a nonzero deviation to the
// skewness steps as well; a single sample goes straight to the result.
// Reset clears all counters and the queue.
// The receiver cannot stall; done_o is high for one cycle.
// ----------------------------------------------------------------------------
module summary_statistics_engine import sse_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] sample_i,
  input  logic               last_sample_i,
  output logic               done_o,
  output logic [12:0]        count_o,
  output logic signed [43:0] total_o,
  output logic signed [31:0] mean_o,
  output logic [47:0]        variance_o,
  output logic [31:0]        std_dev_o,
  output logic [31:0]        std_error_o,
  output logic signed [31:0] minimum_o,
  output logic signed [31:0] maximum_o,
  output logic signed [31:0] skewness_o,
  output logic               overrun_o
);

  logic             push;
  job_t             push_job;
  job_t             head_job;
  logic             q_full;
  logic             q_empty;
  logic             pop;
  logic             pass_done;
  logic             rd_en;
  logic [AddrW-1:0] rd_addr;
  logic [31:0]      rd_data;
  alu_req_t         alu_req;
  logic [AluW-1:0]  alu_a;
  logic [AluW-1:0]  alu_b;
  logic             alu_done;
  logic [AluW-1:0]  alu_res;

  sse_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .sample_i      (sample_i),
    .last_sample_i (last_sample_i),
    .busy          (busy),
    .push_o        (push),
    .job_o         (push_job),
    .full_i        (q_full),
    .pass_done_i   (pass_done),
    .rd_en_i       (rd_en),
    .rd_addr_i     (rd_addr),
    .rd_data_o     (rd_data)
  );

  sse_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .job_o   (head_job),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  sse_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .a_i    (alu_a),
    .b_i    (alu_b),
    .done_o (alu_done),
    .res_o  (alu_res)
  );

  sse_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (head_job),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .pass_done_o (pass_done),
    .alu_req_o   (alu_req),
    .alu_a_o     (alu_a),
    .alu_b_o     (alu_b),
    .alu_done_i  (alu_done),
    .alu_res_i   (alu_res),
    .done_o      (done_o),
    .count_o     (count_o),
    .total_o     (total_o),
    .mean_o      (mean_o),
    .variance_o  (variance_o),
    .std_dev_o   (std_dev_o),
    .std_error_o (std_error_o),
    .minimum_o   (minimum_o),
    .maximum_o   (maximum_o),
    .skewness_o  (skewness_o),
    .overrun_o   (overrun_o)
  );

  a_lock_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && last_sample_i |=> busy)
    else $error("store not locked after last word");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held two cycles");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (count_o != '0) && (minimum_o <= maximum_o))
    else $error("empty set or inverted extremes in result");

  a_no_read_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pass_done |=> !rd_en)
    else $error("store read after pass end");

endmodule

### hdl/sse_alu.sv
// ----------------------------------------------------------------------------
// Shared arithmetic unit
// Shift-add multiplier, restoring divider and bitwise integer square root,
// one step per cycle.
// ----------------------------------------------------------------------------
module sse_alu import sse_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  alu_req_t        req_i,
  input  logic [AluW-1:0] a_i,
  input  logic [AluW-1:0] b_i,
  output logic            done_o,
  output logic [AluW-1:0] res_o
);

  logic               busy_q;
  logic               done_q;
  alu_op_e            op_q;
  logic [AluCntW-1:0] cnt_q;
  logic [AluW-1:0]    x_q;
  logic [AluW-1:0]    y_q;
  logic [AluW-1:0]    p_q;

  logic [AluW:0]   rem2;
  logic            ge;
  logic [63:0]     rb;
  logic            sq_ge;
  logic            last_step;

  assign rem2      = {p_q, y_q[AluW-1]};
  assign ge        = rem2 >= {1'b0, x_q};
  assign rb        = x_q[63:0] + y_q[63:0];
  assign sq_ge     = p_q[63:0] >= rb;
  assign last_step = (op_q == OpMul) ? (y_q == '0) : (cnt_q == AluCntW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= OpMul;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        op_q   <= req_i.op;
        cnt_q  <= (req_i.op == OpDiv) ? AluCntW'(AluW) : AluCntW'(32);
      end else if (busy_q) begin
        cnt_q <= cnt_q - AluCntW'(1);
        if (last_step) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      unique case (req_i.op)
        OpMul: begin
          x_q <= a_i;
          y_q <= b_i;
          p_q <= '0;
        end
        OpDiv: begin
          x_q <= b_i;
          y_q <= a_i;
          p_q <= '0;
        end
        OpSqrt: begin
          x_q <= '0;
          y_q <= AluW'(64'h4000_0000_0000_0000);
          p_q <= {{(AluW-64){1'b0}}, a_i[63:0]};
        end
        default: begin
          x_q <= a_i;
          y_q <= b_i;
          p_q <= '0;
        end
      endcase
    end else if (busy_q) begin
      unique case (op_q)
        OpMul: begin
          if (y_q != '0) begin
            if (y_q[0]) p_q <= p_q + x_q;
            x_q <= x_q << 1;
            y_q <= y_q >> 1;
          end
        end
        OpDiv: begin
          p_q <= ge ? AluW'(rem2 - {1'b0, x_q}) : rem2[AluW-1:0];
          y_q <= {y_q[AluW-2:0], ge};
        end
        OpSqrt: begin
          if (sq_ge) begin
            p_q <= {{(AluW-64){1'b0}}, p_q[63:0] - rb};
            x_q <= {{(AluW-64){1'b0}}, (x_q[63:0] >> 1) + y_q[63:0]};
          end else begin
            x_q <= {{(AluW-64){1'b0}}, x_q[63:0] >> 1};
          end
          y_q <= y_q >> 2;
        end
        default: begin
          p_q <= p_q;
        end
      endcase
    end
  end

  always_comb begin
    unique case (op_q)
      OpDiv:   res_o = y_q;
      OpSqrt:  res_o = x_q;
      default: res_o = p_q;
    endcase
  end

  assign done_o = done_q;

endmodule

### hdl/sse_front.sv
// ----------------------------------------------------------------------------
// Sample loader
// Accepts samples, writes the sample store and keeps count, sum, minimum
// and maximum; the last word of a set is handed on as a job.
// ----------------------------------------------------------------------------
module sse_front import sse_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic [31:0]      sample_i,
  input  logic             last_sample_i,
  output logic             busy,
  output logic             push_o,
  output job_t             job_o,
  input  logic             full_i,
  input  logic             pass_done_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [31:0]      rd_data_o
);

  logic [31:0] mem [MaxSamples];
  logic [31:0] rd_q;

  logic [CntW-1:0]        cnt_q;
  logic signed [SumW-1:0] sum_q;
  logic signed [31:0]     min_q;
  logic signed [31:0]     max_q;
  logic                   ovr_q;
  logic                   lock_q;

  logic                   accept;
  logic                   keep;
  logic signed [31:0]     x;
  logic [CntW-1:0]        cnt_d;
  logic signed [SumW-1:0] sum_d;
  logic signed [31:0]     min_d;
  logic signed [31:0]     max_d;
  logic                   ovr_d;

  assign busy   = lock_q | full_i;
  assign accept = start & ~busy;
  assign keep   = cnt_q < CntW'(MaxSamples);
  assign x      = sample_i;

  always_comb begin
    cnt_d = cnt_q;
    sum_d = sum_q;
    min_d = min_q;
    max_d = max_q;
    ovr_d = ovr_q;
    if (keep) begin
      cnt_d = cnt_q + CntW'(1);
      sum_d = sum_q + {{(SumW-32){x[31]}}, x};
      if (cnt_q == '0 || x < min_q) min_d = x;
      if (cnt_q == '0 || x > max_q) max_d = x;
    end else begin
      ovr_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      sum_q  <= '0;
      min_q  <= '0;
      max_q  <= '0;
      ovr_q  <= 1'b0;
      lock_q <= 1'b0;
    end else begin
      if (pass_done_i) lock_q <= 1'b0;
      if (accept) begin
        if (last_sample_i) begin
          cnt_q  <= '0;
          sum_q  <= '0;
          min_q  <= '0;
          max_q  <= '0;
          ovr_q  <= 1'b0;
          lock_q <= 1'b1;
        end else begin
          cnt_q <= cnt_d;
          sum_q <= sum_d;
          min_q <= min_d;
          max_q <= max_d;
          ovr_q <= ovr_d;
        end
      end
    end
  end

  assign push_o = accept & last_sample_i;
  assign job_o  = '{n: cnt_d, sum: sum_d, min: min_d, max: max_d, ovr: ovr_d};

  always_ff @(posedge clk_i) begin
    if (accept && keep) mem[cnt_q[AddrW-1:0]] <= sample_i;
    if (rd_en_i) rd_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_q;

endmodule

### hdl/sse_queue.sv
// ----------------------------------------------------------------------------
// Job queue
// Two-entry queue of finished data set descriptors.
// ----------------------------------------------------------------------------
module sse_queue import sse_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output job_t job_o,
  output logic full_o,
  output logic empty_o
);

  job_t       slot_q [2];
  logic       wp_q;
  logic       rp_q;
  logic [1:0] fill_q;

  assign full_o  = fill_q == 2'd2;
  assign empty_o = fill_q == 2'd0;
  assign job_o   = slot_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= 1'b0;
      rp_q   <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      fill_q <= fill_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wp_q] <= job_i;
  end

endmodule

### hdl/sse_back.sv
// ----------------------------------------------------------------------------
// Statistics sequencer
// Computes the mean, passes over the store for the deviation moments and
// then runs variance, root and skewness steps on the shared unit as the set allows.
// ----------------------------------------------------------------------------
module sse_back import sse_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  job_t               job_i,
  input  logic               empty_i,
  output logic               pop_o,
  output logic               rd_en_o,
  output logic [AddrW-1:0]   rd_addr_o,
  input  logic [31:0]        rd_data_i,
  output logic               pass_done_o,
  output alu_req_t           alu_req_o,
  output logic [AluW-1:0]    alu_a_o,
  output logic [AluW-1:0]    alu_b_o,
  input  logic               alu_done_i,
  input  logic [AluW-1:0]    alu_res_i,
  output logic               done_o,
  output logic [12:0]        count_o,
  output logic signed [43:0] total_o,
  output logic signed [31:0] mean_o,
  output logic [47:0]        variance_o,
  output logic [31:0]        std_dev_o,
  output logic [31:0]        std_error_o,
  output logic signed [31:0] minimum_o,
  output logic signed [31:0] maximum_o,
  output logic signed [31:0] skewness_o,
  output logic               overrun_o
);

  typedef enum logic [14:0] {
    StIdle   = 15'b000000000000001,
    StMean   = 15'b000000000000010,
    StPass   = 15'b000000000000100,
    StVarMul = 15'b000000000001000,
    StVarSq  = 15'b000000000010000,
    StVarDen = 15'b000000000100000,
    StVarDiv = 15'b000000001000000,
    StSdRoot = 15'b000000010000000,
    StSeDiv  = 15'b000000100000000,
    StSeRoot = 15'b000001000000000,
    StSkMul  = 15'b000010000000000,
    StSkDen  = 15'b000100000000000,
    StSkCube = 15'b001000000000000,
    StSkDiv  = 15'b010000000000000,
    StOut    = 15'b100000000000000
  } state_e;

  state_e          state_q;
  logic            issued_q;
  logic [1:0]      cube_k_q;
  logic [CntW-1:0] iss_q;
  logic            v1_q, v2_q, v3_q, v4_q, v5_q;
  logic            done_q;

  job_t               job_q;
  logic signed [31:0] mean_q;
  logic signed [45:0] d1_q;
  logic [75:0]        d2_q;
  logic [107:0]       pos_q;
  logic [107:0]       neg_q;
  logic [AluW-1:0]    t0_q;
  logic [AluW-1:0]    t1_q;
  logic [63:0]        q0_q;
  logic [47:0]        var_q;
  logic [31:0]        sd_q;
  logic [31:0]        se_q;
  logic signed [31:0] skew_q;
  logic               sk_neg_q;

  logic [31:0] a2_q;
  logic        n2_q;
  logic [63:0] sq3_q;
  logic [31:0] a3_q;
  logic        n3_q;
  logic [63:0] clo4_q;
  logic [31:0] shi4_q;
  logic [31:0] a4_q;
  logic        n4_q;
  logic [95:0] cube5_q;
  logic        n5_q;

  logic            arith;
  logic            step_done;
  logic            pass_end;
  logic [SumW-1:0] sum_mag;
  logic [45:0]     d1_mag;
  logic            pn_neg;
  logic [107:0]    pn_diff;
  logic [32:0]     d;
  logic [32:0]     d_neg;
  logic [63:0]     q0_d;
  logic [63:0]     var_w;

  assign arith = (state_q != StIdle) && (state_q != StPass) && (state_q != StOut);
  assign step_done = arith && issued_q && alu_done_i;
  assign pass_end = (state_q == StPass) && (iss_q == job_q.n) &&
                    !(v1_q | v2_q | v3_q | v4_q | v5_q);
  assign pass_done_o = pass_end;
  assign pop_o     = (state_q == StIdle) && !empty_i;
  assign rd_en_o   = (state_q == StPass) && (iss_q != job_q.n);
  assign rd_addr_o = iss_q[AddrW-1:0];

  assign sum_mag = job_q.sum[SumW-1] ? SumW'(~job_q.sum + SumW'(1)) : SumW'(job_q.sum);
  assign d1_mag  = d1_q[45] ? 46'(~d1_q + 46'd1) : 46'(d1_q);
  assign pn_neg  = pos_q < neg_q;
  assign pn_diff = pn_neg ? (neg_q - pos_q) : (pos_q - neg_q);
  assign d       = {rd_data_i[31], rd_data_i} - {mean_q[31], mean_q};
  assign d_neg   = ~d + 33'd1;
  assign q0_d    = (|alu_res_i[AluW-1:64]) ? '1 : alu_res_i[63:0];
  assign var_w   = q0_d >> FracBits;

  always_comb begin
    alu_req_o.start = arith && !issued_q;
    alu_req_o.op    = OpMul;
    alu_a_o         = '0;
    alu_b_o         = '0;
    unique case (state_q)
      StMean: begin
        alu_req_o.op = OpDiv;
        alu_a_o      = (AluW'(sum_mag) << 1) + AluW'(job_q.n);
        alu_b_o      = AluW'(job_q.n) << 1;
      end
      StVarMul: begin
        alu_a_o = AluW'(d2_q);
        alu_b_o = AluW'(job_q.n);
      end
      StVarSq: begin
        alu_a_o = AluW'(d1_mag);
        alu_b_o = AluW'(d1_mag);
      end
      StVarDen: begin
        alu_a_o = AluW'(job_q.n);
        alu_b_o = AluW'(job_q.n) - AluW'(1);
      end
      StVarDiv: begin
        alu_req_o.op = OpDiv;
        alu_a_o      = t0_q;
        alu_b_o      = t1_q;
      end
      StSdRoot: begin
        alu_req_o.op = OpSqrt;
        alu_a_o      = AluW'(q0_q);
      end
      StSeDiv: begin
        alu_req_o.op = OpDiv;
        alu_a_o      = AluW'(q0_q);
        alu_b_o      = AluW'(job_q.n);
      end
      StSeRoot: begin
        alu_req_o.op = OpSqrt;
        alu_a_o      = t0_q;
      end
      StSkMul: begin
        alu_a_o = AluW'(pn_diff);
        alu_b_o = AluW'(job_q.n);
      end
      StSkDen: begin
        alu_a_o = AluW'(job_q.n) - AluW'(1);
        alu_b_o = AluW'(job_q.n) - AluW'(2);
      end
      StSkCube: begin
        alu_a_o = t1_q;
        alu_b_o = AluW'(sd_q);
      end
      StSkDiv: begin
        alu_req_o.op = OpDiv;
        alu_a_o      = t0_q;
        alu_b_o      = t1_q;
      end
      default: begin
        alu_req_o.op = OpMul;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      issued_q <= 1'b0;
      cube_k_q <= '0;
      iss_q    <= '0;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
      v4_q     <= 1'b0;
      v5_q     <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;
      v1_q   <= rd_en_o;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      v4_q   <= v3_q;
      v5_q   <= v4_q;
      if (rd_en_o) iss_q <= iss_q + CntW'(1);
      if (alu_req_o.start) issued_q <= 1'b1;
      if (step_done) issued_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (!empty_i) state_q <= StMean;
        end
        StMean: begin
          if (step_done) begin
            iss_q   <= '0;
            state_q <= StPass;
          end
        end
        StPass: begin
          if (pass_end) state_q <= (job_q.n > CntW'(1)) ? StVarMul : StOut;
        end
        StVarMul: if (step_done) state_q <= StVarSq;
        StVarSq:  if (step_done) state_q <= StVarDen;
        StVarDen: if (step_done) state_q <= StVarDiv;
        StVarDiv: if (step_done) state_q <= StSdRoot;
        StSdRoot: if (step_done) state_q <= StSeDiv;
        StSeDiv:  if (step_done) state_q <= StSeRoot;
        StSeRoot: begin
          if (step_done) state_q <= ((job_q.n > CntW'(2)) && (sd_q != '0)) ? StSkMul : StOut;
        end
        StSkMul: if (step_done) state_q <= StSkDen;
        StSkDen: begin
          if (step_done) begin
            cube_k_q <= '0;
            state_q  <= StSkCube;
          end
        end
        StSkCube: begin
          if (step_done) begin
            cube_k_q <= cube_k_q + 2'd1;
            if (cube_k_q == 2'd2) state_q <= StSkDiv;
          end
        end
        StSkDiv: if (step_done) state_q <= StOut;
        StOut: begin
          done_q  <= 1'b1;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q  <= job_i;
      d1_q   <= '0;
      d2_q   <= '0;
      pos_q  <= '0;
      neg_q  <= '0;
      var_q  <= '0;
      sd_q   <= '0;
      se_q   <= '0;
      skew_q <= '0;
    end
    if (v1_q) begin
      a2_q <= d[32] ? d_neg[31:0] : d[31:0];
      n2_q <= d[32];
      d1_q <= d1_q + {{13{d[32]}}, d};
    end
    if (v2_q) begin
      sq3_q <= 64'(a2_q) * 64'(a2_q);
      a3_q  <= a2_q;
      n3_q  <= n2_q;
    end
    if (v3_q) begin
      clo4_q <= 64'(sq3_q[31:0]) * 64'(a3_q);
      shi4_q <= sq3_q[63:32];
      a4_q   <= a3_q;
      n4_q   <= n3_q;
      d2_q   <= d2_q + 76'(sq3_q);
    end
    if (v4_q) begin
      cube5_q <= {64'(shi4_q) * 64'(a4_q), 32'd0} + {32'd0, clo4_q};
      n5_q    <= n4_q;
    end
    if (v5_q) begin
      if (n5_q) neg_q <= neg_q + 108'(cube5_q);
      else pos_q <= pos_q + 108'(cube5_q);
    end
    if (step_done) begin
      unique case (state_q)
        StMean: begin
          mean_q <= job_q.sum[SumW-1] ? (~alu_res_i[31:0] + 32'd1) : alu_res_i[31:0];
        end
        StVarMul: t0_q <= alu_res_i;
        StVarSq:  t0_q <= t0_q - alu_res_i;
        StVarDen: t1_q <= alu_res_i;
        StVarDiv: begin
          q0_q  <= q0_d;
          var_q <= (|var_w[63:48]) ? '1 : var_w[47:0];
        end
        StSdRoot: sd_q <= alu_res_i[31:0];
        StSeDiv:  t0_q <= alu_res_i;
        StSeRoot: se_q <= alu_res_i[31:0];
        StSkMul: begin
          t0_q     <= alu_res_i << FracBits;
          sk_neg_q <= pn_neg;
        end
        StSkDen:  t1_q <= alu_res_i;
        StSkCube: t1_q <= alu_res_i;
        StSkDiv: begin
          if (sk_neg_q) begin
            skew_q <= (alu_res_i > AluW'(32'h8000_0000)) ? 32'sh8000_0000 :
                      -$signed(alu_res_i[31:0]);
          end else begin
            skew_q <= (|alu_res_i[AluW-1:31]) ? 32'sh7FFF_FFFF : $signed(alu_res_i[31:0]);
          end
        end
        default: t0_q <= t0_q;
      endcase
    end
  end

  assign done_o      = done_q;
  assign count_o     = job_q.n;
  assign total_o     = job_q.sum;
  assign mean_o      = mean_q;
  assign variance_o  = var_q;
  assign std_dev_o   = sd_q;
  assign std_error_o = se_q;
  assign minimum_o   = job_q.min;
  assign maximum_o   = job_q.max;
  assign skewness_o  = skew_q;
  assign overrun_o   = job_q.ovr;

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// Summary statistics engine testbench
// Sends data sets of signed Q16.16 samples and checks every reported word
// (count, sum, mean, variance, deviations, extremes, skewness, overrun)
// against an exact wide-integer prediction, with random gaps on the input.
// ----------------------------------------------------------------------------
module tb_top import sse_pkg::*; ();

  typedef struct {
    logic [12:0]        count;
    logic signed [43:0] total;
    logic signed [31:0] mean;
    logic [47:0]        variance;
    logic [31:0]        std_dev;
    logic [31:0]        std_error;
    logic signed [31:0] minimum;
    logic signed [31:0] maximum;
    logic signed [31:0] skewness;
    logic               overrun;
  } stats_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic signed [31:0] sample_i;
  logic               last_sample_i;
  logic               done_o;
  logic [12:0]        count_o;
  logic signed [43:0] total_o;
  logic signed [31:0] mean_o;
  logic [47:0]        variance_o;
  logic [31:0]        std_dev_o;
  logic [31:0]        std_error_o;
  logic signed [31:0] minimum_o;
  logic signed [31:0] maximum_o;
  logic signed [31:0] skewness_o;
  logic               overrun_o;

  stats_t             stats_q[$];
  logic signed [31:0] set_samples[$];
  longint             set_sum;
  longint             set_min;
  longint             set_max;
  bit                 set_ovr;
  int                 errors;

  summary_statistics_engine u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .sample_i     (sample_i),
    .last_sample_i(last_sample_i),
    .done_o       (done_o),
    .count_o      (count_o),
    .total_o      (total_o),
    .mean_o       (mean_o),
    .variance_o   (variance_o),
    .std_dev_o    (std_dev_o),
    .std_error_o  (std_error_o),
    .minimum_o    (minimum_o),
    .maximum_o    (maximum_o),
    .skewness_o   (skewness_o),
    .overrun_o    (overrun_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] sat64(logic [191:0] v);
    return (v[191:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : v[63:0];
  endfunction

  // Closes the current data set and computes the statistics word it reports.
  function automatic stats_t close_set();
    stats_t       r;
    longint       n;
    longint       mag;
    longint       mean;
    longint       d;
    longint       d1;
    logic [63:0]  a;
    logic [63:0]  ad1;
    logic [191:0] sq_sum;
    logic [191:0] pos;
    logic [191:0] neg;
    logic [191:0] t;
    logic [191:0] num;
    logic [191:0] den;
    logic [63:0]  q0;
    logic [63:0]  v;
    logic [63:0]  vr;
    logic [63:0]  sd;
    logic [63:0]  se;
    bit           negative;
    n = set_samples.size();
    mag = set_sum < 0 ? -set_sum : set_sum;
    mag = (2 * mag + n) / (2 * n);
    mean = set_sum < 0 ? -mag : mag;
    d1 = 0;
    sq_sum = '0;
    pos = '0;
    neg = '0;
    foreach (set_samples[i]) begin
      d = longint'(set_samples[i]) - mean;
      a = d < 0 ? -d : d;
      d1 += d;
      t = 192'(a) * 192'(a);
      sq_sum += t;
      t = t * 192'(a);
      if (d > 0) pos += t;
      if (d < 0) neg += t;
    end
    vr = 0;
    sd = 0;
    se = 0;
    if (n > 1) begin
      ad1 = d1 < 0 ? -d1 : d1;
      num = sq_sum * 192'(n) - 192'(ad1) * 192'(ad1);
      den = 192'(n * (n - 1));
      q0 = sat64(num / den);
      vr = q0 >> FracBits;
      if (vr > 64'hFFFF_FFFF_FFFF) vr = 64'hFFFF_FFFF_FFFF;
      sd = int_sqrt(q0);
      if (sd > 64'hFFFF_FFFF) sd = 64'hFFFF_FFFF;
      se = int_sqrt(q0 / n);
      if (se > 64'hFFFF_FFFF) se = 64'hFFFF_FFFF;
    end
    r.skewness = '0;
    if (n > 2 && sd > 0) begin
      negative = pos < neg;
      num = negative ? neg - pos : pos - neg;
      num = num * 192'(n) * (192'(1) << FracBits);
      den = 192'((n - 1) * (n - 2)) * 192'(sd) * 192'(sd) * 192'(sd);
      v = sat64(num / den);
      if (negative) begin
        if (v > 64'h8000_0000) v = 64'h8000_0000;
        r.skewness = 32'(-longint'(v));
      end else begin
        if (v > 64'h7FFF_FFFF) v = 64'h7FFF_FFFF;
        r.skewness = 32'(v);
      end
    end
    r.count     = 13'(n);
    r.total     = 44'(set_sum);
    r.mean      = 32'(mean);
    r.variance  = 48'(vr);
    r.std_dev   = 32'(sd);
    r.std_error = 32'(se);
    r.minimum   = 32'(set_min);
    r.maximum   = 32'(set_max);
    r.overrun   = set_ovr;
    set_samples.delete();
    set_sum = 0;
    set_ovr = 0;
    return r;
  endfunction

  function automatic void load_sample(logic signed [31:0] x, bit last);
    if (set_samples.size() < MaxSamples) begin
      if (set_samples.size() == 0) begin
        set_min = longint'(x);
        set_max = longint'(x);
      end
      if (longint'(x) < set_min) set_min = longint'(x);
      if (longint'(x) > set_max) set_max = longint'(x);
      set_sum += longint'(x);
      set_samples.push_back(x);
    end else begin
      set_ovr = 1;
    end
    if (last) stats_q.push_back(close_set());
  endfunction

  task automatic send_word(logic signed [31:0] x, bit last, bit gaps = 1);
    int gap;
    start         <= 1'b1;
    sample_i      <= x;
    last_sample_i <= last;
    do @(posedge clk_i); while (busy);
    load_sample(x, last);
    gap = 0;
    if (gaps) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: gap = 0;
        5, 6, 7, 8:    gap = $urandom_range(1, 3);
        default:       gap = $urandom_range(4, 40);
      endcase
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic logic signed [31:0] rand_sample(int kind);
    case (kind)
      0:       return $urandom;
      1:       return $signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000;
      2:       return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return $signed($urandom_range(0, 255)) - 128;
    endcase
  endfunction

  task automatic send_set(int n, int kind);
    for (int i = 0; i < n; i++) send_word(rand_sample(kind), i == n - 1);
  endtask

  task automatic test_extremes();
    send_word(32'sh7FFF_FFFF, 1'b1);
    send_word(32'sh8000_0000, 1'b1);
    send_word(32'sh7FFF_FFFF, 1'b0);
    send_word(32'sh8000_0000, 1'b1);
    send_word(32'sh8000_0000, 1'b0);
    send_word(32'sh8000_0000, 1'b0);
    send_word(32'sh7FFF_FFFF, 1'b1);
  endtask

  task automatic test_small_sets();
    send_word(32'sh0001_0000, 1'b0);
    send_word(32'sh0003_0000, 1'b1);
    send_word(-32'sd1, 1'b0);
    send_word(32'sd0, 1'b1);
    send_word(32'sd1, 1'b0);
    send_word(32'sd0, 1'b1);
    for (int i = 0; i < 4; i++) send_word(32'sh0002_8000, i == 3);
  endtask

  task automatic test_skew_sign();
    send_word(32'sd0, 1'b0);
    send_word(32'sd0, 1'b0);
    send_word(32'sd0, 1'b0);
    send_word(-32'sh0010_0000, 1'b1);
    send_word(32'sd0, 1'b0);
    send_word(32'sd0, 1'b0);
    send_word(32'sd0, 1'b0);
    send_word(32'sh0010_0000, 1'b1);
  endtask

  task automatic test_random();
    int sent;
    int n;
    sent = 0;
    while (sent < 875) begin
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 12);
      send_set(n, $urandom_range(0, 3));
      sent += n;
    end
  endtask

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    stats_t e;
    if (rst_ni && done_o) begin
      if (stats_q.size() == 0) begin
        $display("%0t: result word with none expected: expected none, actual count %0d",
                 $time, count_o);
        errors++;
      end else begin
        e = stats_q.pop_front();
        check_field("count", 64'(e.count), 64'(count_o));
        check_field("total", 64'(e.total), 64'(total_o));
        check_field("mean", 64'(e.mean), 64'(mean_o));
        check_field("variance", 64'(e.variance), 64'(variance_o));
        check_field("std_dev", 64'(e.std_dev), 64'(std_dev_o));
        check_field("std_error", 64'(e.std_error), 64'(std_error_o));
        check_field("minimum", 64'(e.minimum), 64'(minimum_o));
        check_field("maximum", 64'(e.maximum), 64'(maximum_o));
        check_field("skewness", 64'(e.skewness), 64'(skewness_o));
        check_field("overrun", 64'(e.overrun), 64'(overrun_o));
      end
    end
  end

  initial begin
    #50_000_000;
    $display("[summary_statistics_engine] ERROR");
    $finish;
  end

  initial begin
    errors = 0;
    set_sum = 0;
    set_min = 0;
    set_max = 0;
    set_ovr = 0;
    start = 1'b0;
    sample_i = '0;
    last_sample_i = 1'b0;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat ($urandom_range(1, 5)) @(posedge clk_i);
    test_extremes();
    test_small_sets();
    test_skew_sign();
    test_random();
    start <= 1'b0;
    while (stats_q.size() != 0) @(posedge clk_i);
    repeat (1200) @(posedge clk_i);
    if (errors == 0 && stats_q.size() == 0) begin
      $display("[summary_statistics_engine] OK");
    end else begin
      $display("[summary_statistics_engine] ERROR");
    end
    $finish;
  end

endmodule
